// File: src/accumulator_cpu_8bit_step_unit_defines.svh
// assertion macros for the accumulator cpu step unit
// needs clk and rst_n in the scope where a macro is used
`ifndef ACCUMULATOR_CPU_8BIT_STEP_UNIT_DEFINES_SVH
`define ACCUMULATOR_CPU_8BIT_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define ACS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/acs_pkg.sv
// shared widths, request codes, opcodes and decode helpers
// for the accumulator cpu step unit; no dependencies
package acs_pkg;

    localparam int BYTE_W    = 8;
    localparam int REQ_W     = 2;
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_EXEC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // don't-care masks by opcode group
    localparam logic [BYTE_W-1:0] MASK_BASIC = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_JUMP  = 8'hFC;
    localparam logic [BYTE_W-1:0] MASK_SHIFT = 8'hF3;
    localparam logic [BYTE_W-1:0] GRP_JUMP   = 8'h90;
    localparam logic [BYTE_W-1:0] GRP_SHIFT  = 8'hC0;
    localparam logic [BYTE_W-1:0] GRP_HALT   = 8'hF0;

    localparam logic [BYTE_W-1:0] SIGN_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] ALL_ONES   = 8'hFF;
    localparam logic [BYTE_W-1:0] PC_SHORT   = 8'h01;
    localparam logic [BYTE_W-1:0] PC_LONG    = 8'h02;

    // opcodes after masking
    localparam logic [BYTE_W-1:0] OP_NOP = 8'h00;
    localparam logic [BYTE_W-1:0] OP_STA = 8'h10;
    localparam logic [BYTE_W-1:0] OP_LDA = 8'h20;
    localparam logic [BYTE_W-1:0] OP_ADD = 8'h30;
    localparam logic [BYTE_W-1:0] OP_OR  = 8'h40;
    localparam logic [BYTE_W-1:0] OP_AND = 8'h50;
    localparam logic [BYTE_W-1:0] OP_NOT = 8'h60;
    localparam logic [BYTE_W-1:0] OP_SUB = 8'h70;
    localparam logic [BYTE_W-1:0] OP_JMP = 8'h80;
    localparam logic [BYTE_W-1:0] OP_JN  = 8'h90;
    localparam logic [BYTE_W-1:0] OP_JP  = 8'h94;
    localparam logic [BYTE_W-1:0] OP_JV  = 8'h98;
    localparam logic [BYTE_W-1:0] OP_JNV = 8'h9C;
    localparam logic [BYTE_W-1:0] OP_JZ  = 8'hA0;
    localparam logic [BYTE_W-1:0] OP_JNZ = 8'hA4;
    localparam logic [BYTE_W-1:0] OP_JC  = 8'hB0;
    localparam logic [BYTE_W-1:0] OP_JNC = 8'hB4;
    localparam logic [BYTE_W-1:0] OP_JB  = 8'hB8;
    localparam logic [BYTE_W-1:0] OP_JNB = 8'hBC;
    localparam logic [BYTE_W-1:0] OP_SHR = 8'hE0;
    localparam logic [BYTE_W-1:0] OP_SHL = 8'hE1;
    localparam logic [BYTE_W-1:0] OP_ROR = 8'hE2;
    localparam logic [BYTE_W-1:0] OP_ROL = 8'hE3;
    localparam logic [BYTE_W-1:0] OP_HLT = 8'hF0;

    typedef struct packed {
        logic b;
        logic c;
        logic v;
        logic z;
        logic n;
    } flags_t;

    function automatic logic [BYTE_W-1:0] acs_decode(input logic [BYTE_W-1:0] v);
        if (v < GRP_JUMP || v >= GRP_HALT)
            return v & MASK_BASIC;
        else if (v < GRP_SHIFT)
            return v & MASK_JUMP;
        else
            return v & MASK_SHIFT;
    endfunction

    function automatic logic acs_has_address(input logic [BYTE_W-1:0] op);
        logic r;
        case (op)
            OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND, OP_SUB, OP_JMP,
            OP_JN, OP_JP, OP_JV, OP_JNV, OP_JZ, OP_JNZ,
            OP_JC, OP_JNC, OP_JB, OP_JNB: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: src/acs_if.sv
// command and response channel interfaces of the accumulator cpu step unit
// depends on acs_pkg
interface acs_cmd_if;
    import acs_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] write_data;

    modport source (output valid, req_type, address, write_data, input ready);
    modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

interface acs_rsp_if;
    import acs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pc_out;
    logic [BYTE_W-1:0] acc_out;
    logic              flag_n;
    logic              flag_z;
    logic              flag_v;
    logic              flag_c;
    logic              flag_b;
    logic              halted;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, pc_out, acc_out, flag_n, flag_z, flag_v, flag_c,
                    flag_b, halted, read_data, input ready);
    modport sink   (input valid, pc_out, acc_out, flag_n, flag_z, flag_v, flag_c,
                    flag_b, halted, read_data, output ready);
endinterface

// File: src/accumulator_cpu_8bit_step_unit.sv
// channel  | dir | handshake    | word
// cmd      | in  | valid/ready  | req_type, address, write_data
// rsp      | out | valid/ready  | pc_out, acc_out, flags, halted, read_data
// cfg      | in  | cfg_we       | cfg_wdata = break address
//
// an instruction with address byte reads the opcode at launch, then the address byte,
// then the operand on the single memory port, and executes in its last step; a one-byte
// instruction executes in S_FETCH, a host write completes at launch, a host read in S_HREAD
// reset: a clearing pass writes zero to every memory byte, cmd.ready stays low
// stalls: one command word is buffered; a finished word sits in the response
// register and the sequencer waits before its last step while that is full
//
// accumulator cpu step unit: single-port memory, sequencer, registered response
// depends on acs_pkg, acs_if and the assertion macro header
`include "accumulator_cpu_8bit_step_unit_defines.svh"

module accumulator_cpu_8bit_step_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [acs_pkg::BYTE_W-1:0] cfg_wdata,
    acs_cmd_if.sink                    cmd,
    acs_rsp_if.source                  rsp
);
    import acs_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_TARGET,
        S_OPERAND,
        S_HREAD
    } state_t;

    state_t            state_reg, state_next;
    logic [MEM_AW-1:0] clr_addr_reg, clr_addr_next;
    logic              buf_valid_reg, buf_valid_next;
    logic [REQ_W-1:0]  buf_req_reg;
    logic [BYTE_W-1:0] buf_addr_reg, buf_wdata_reg;
    logic [BYTE_W-1:0] pc_reg, pc_next;
    logic [BYTE_W-1:0] acc_reg, acc_next;
    flags_t            flags_reg, flags_next;
    logic [BYTE_W-1:0] brk_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] op_reg, op_next;
    logic [BYTE_W-1:0] target_reg, target_next;
    logic              halted_reg, halted_next;
    logic [BYTE_W-1:0] rdata_reg, rdata_next;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] mem_rd_reg;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    logic              cmd_fire, buf_pop, finish, out_free;
    logic [BYTE_W-1:0] cur_op, pc_inc;
    logic [BYTE_W-1:0] acc_exec;
    flags_t            flags_exec;
    logic              jump_exec;
    logic [BYTE_W:0]   sum;
    logic [BYTE_W-1:0] diff;

    assign cmd.ready = !buf_valid_reg && (state_reg != S_CLEAR);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.pc_out    = pc_reg;
    assign rsp.acc_out   = acc_reg;
    assign rsp.flag_n    = flags_reg.n;
    assign rsp.flag_z    = flags_reg.z;
    assign rsp.flag_v    = flags_reg.v;
    assign rsp.flag_c    = flags_reg.c;
    assign rsp.flag_b    = flags_reg.b;
    assign rsp.halted    = halted_reg;
    assign rsp.read_data = rdata_reg;

    // single-port memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            mem_rd_reg <= mem[mem_addr];
        end
    end

    // opcode comes straight from memory in fetch, else from the held copy
    assign cur_op = (state_reg == S_FETCH) ? acs_decode(mem_rd_reg) : op_reg;
    assign pc_inc = (state_reg == S_FETCH) ? pc_reg + PC_SHORT : pc_reg + PC_LONG;
    assign sum    = {1'b0, acc_reg} + {1'b0, mem_rd_reg};
    assign diff   = acc_reg - mem_rd_reg;

    always_comb
    begin
        acc_exec   = acc_reg;
        flags_exec = flags_reg;
        jump_exec  = 1'b0;
        case (cur_op)
            OP_LDA: acc_exec = mem_rd_reg;
            OP_ADD:
            begin
                acc_exec     = sum[BYTE_W-1:0];
                flags_exec.c = sum[BYTE_W];
                flags_exec.v = ~(acc_reg[BYTE_W-1] ^ mem_rd_reg[BYTE_W-1])
                             & (acc_reg[BYTE_W-1] ^ sum[BYTE_W-1]);
            end
            OP_OR:  acc_exec = acc_reg | mem_rd_reg;
            OP_AND: acc_exec = acc_reg & mem_rd_reg;
            OP_NOT: acc_exec = acc_reg ^ ALL_ONES;
            OP_SUB:
            begin
                acc_exec     = diff;
                flags_exec.b = acc_reg < mem_rd_reg;
                flags_exec.v = (acc_reg[BYTE_W-1] ^ mem_rd_reg[BYTE_W-1])
                             & (acc_reg[BYTE_W-1] ^ diff[BYTE_W-1]);
            end
            OP_JMP: jump_exec = 1'b1;
            OP_JN:  jump_exec = flags_reg.n;
            OP_JP:  jump_exec = !flags_reg.n;
            OP_JV:  jump_exec = flags_reg.v;
            OP_JNV: jump_exec = !flags_reg.v;
            OP_JZ:  jump_exec = flags_reg.z;
            OP_JNZ: jump_exec = !flags_reg.z;
            OP_JC:  jump_exec = flags_reg.c;
            OP_JNC: jump_exec = !flags_reg.c;
            OP_JB:  jump_exec = flags_reg.b;
            OP_JNB: jump_exec = !flags_reg.b;
            OP_SHR:
            begin
                acc_exec     = {1'b0, acc_reg[BYTE_W-1:1]};
                flags_exec.c = acc_reg[0];
            end
            OP_SHL:
            begin
                acc_exec     = {acc_reg[BYTE_W-2:0], 1'b0};
                flags_exec.c = acc_reg[BYTE_W-1];
            end
            OP_ROR:
            begin
                acc_exec     = {flags_reg.c, acc_reg[BYTE_W-1:1]};
                flags_exec.c = acc_reg[0];
            end
            OP_ROL:
            begin
                acc_exec     = {acc_reg[BYTE_W-2:0], flags_reg.c};
                flags_exec.c = acc_reg[BYTE_W-1];
            end
            default: acc_exec = acc_reg;
        endcase
        flags_exec.z = (acc_exec == '0);
        flags_exec.n = |(acc_exec & SIGN_BIT);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        flags_next     = flags_reg;
        op_next        = op_reg;
        target_next    = target_reg;
        halted_next    = halted_reg;
        rdata_next     = rdata_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = pc_reg;
        mem_wdata      = acc_reg;
        buf_pop        = 1'b0;
        finish         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == MEM_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    case (buf_req_reg)
                        REQ_EXEC:
                        begin
                            mem_re     = 1'b1;
                            mem_addr   = pc_reg;
                            buf_pop    = 1'b1;
                            state_next = S_FETCH;
                        end
                        REQ_WRITE:
                        begin
                            if (out_free)
                            begin
                                mem_we      = 1'b1;
                                mem_addr    = buf_addr_reg;
                                mem_wdata   = buf_wdata_reg;
                                buf_pop     = 1'b1;
                                finish      = 1'b1;
                                halted_next = 1'b0;
                                rdata_next  = '0;
                            end
                        end
                        REQ_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_addr   = buf_addr_reg;
                            buf_pop    = 1'b1;
                            state_next = S_HREAD;
                        end
                        default:
                        begin
                            // unused request: report pc, accumulator and flags unchanged, halted and read data cleared
                            if (out_free)
                            begin
                                buf_pop     = 1'b1;
                                finish      = 1'b1;
                                halted_next = 1'b0;
                                rdata_next  = '0;
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (acs_has_address(cur_op))
                begin
                    mem_re     = 1'b1;
                    mem_addr   = pc_reg + PC_SHORT;
                    op_next    = cur_op;
                    state_next = S_TARGET;
                end
                else if (out_free)
                begin
                    acc_next    = acc_exec;
                    flags_next  = flags_exec;
                    pc_next     = pc_inc;
                    halted_next = (pc_inc == brk_reg) || (cur_op == OP_HLT);
                    rdata_next  = '0;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TARGET:
            begin
                target_next = mem_rd_reg;
                mem_re      = 1'b1;
                mem_addr    = mem_rd_reg;
                state_next  = S_OPERAND;
            end
            S_OPERAND:
            begin
                if (out_free)
                begin
                    if (cur_op == OP_STA)
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = target_reg;
                        mem_wdata = acc_reg;
                    end
                    acc_next    = acc_exec;
                    flags_next  = flags_exec;
                    pc_next     = jump_exec ? target_reg : pc_inc;
                    halted_next = (pc_inc == brk_reg);
                    rdata_next  = '0;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_HREAD:
            begin
                if (out_free)
                begin
                    rdata_next  = mem_rd_reg;
                    halted_next = 1'b0;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        buf_valid_next = buf_valid_reg;
        if (buf_pop)
            buf_valid_next = 1'b0;
        if (cmd_fire)
            buf_valid_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            acc_reg       <= '0;
            flags_reg     <= '{b: 1'b0, c: 1'b0, v: 1'b0, z: 1'b1, n: 1'b0};
            brk_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            flags_reg     <= flags_next;
            if (cfg_we)
                brk_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            buf_req_reg   <= cmd.req_type;
            buf_addr_reg  <= cmd.address;
            buf_wdata_reg <= cmd.write_data;
        end
        op_reg     <= op_next;
        target_reg <= target_next;
        halted_reg <= halted_next;
        rdata_reg  <= rdata_next;
    end

    `ACS_ASSERT_NOW(a_port_single, 1'b1, !(mem_we && mem_re), "memory read and write together")
    `ACS_ASSERT_NOW(a_launch_buf, (state_reg == S_IDLE) && (state_next != S_IDLE), buf_valid_reg, "sequencer left idle without a command")
    `ACS_ASSERT_NOW(a_no_overrun, out_valid_reg && !rsp.ready, !finish, "response overwritten while held")
    `ACS_ASSERT_NOW(a_host_pc, finish && (state_reg == S_HREAD), pc_next == pc_reg, "host read moved the program counter")
    `ACS_ASSERT_NOW(a_zero_flag, out_valid_reg, flags_reg.z == (acc_reg == '0), "zero flag out of step with accumulator")

endmodule
